// ===== design/vpr_pkg.sv =====
// Shared constants, types and functions for the vector polar/rotate CORDIC.
`timescale 1ns / 1ps
package vpr_pkg;

	localparam int DATA_W  = 16;
	localparam int ANG_W   = 16;
	localparam int GUARD_W = 16;
	localparam int ANG_SH  = 16;
	localparam int ITER    = 16;
	localparam int XW      = DATA_W + GUARD_W + 3;
	localparam int ZW      = 34;
	localparam int OW      = DATA_W + 1;
	localparam int SHW     = 5;
	localparam int SPLIT   = 24;
	localparam int HIW     = XW - SPLIT;
	localparam int GW      = 32;
	localparam int HPW     = HIW + GW + 1;
	localparam int QW      = HPW + 1;
	localparam int RW      = QW - SPLIT;
	localparam int AW      = ZW + 1 - ANG_SH;
	localparam int SATW    = QW;
	localparam int NTAB    = 24;

	localparam logic [GW-1:0] GAIN = 32'd2608131496;
	localparam logic signed [ZW-1:0] QUARTER = ZW'(32'sd1073741824);
	localparam logic signed [QW-1:0] RND = QW'(64'sd1) <<< (SPLIT - 1);
	localparam logic signed [ZW:0] ANG_RND = (ZW + 1)'(64'sd1) <<< (ANG_SH - 1);

	localparam logic [31:0] ATAN_TAB [NTAB] = '{
		32'd536870912, 32'd316933405, 32'd167458907, 32'd85004756,
		32'd42667331,  32'd21354465,  32'd10680862,  32'd5340245,
		32'd2670163,   32'd1335086,   32'd667544,    32'd333772,
		32'd166886,    32'd83443,     32'd41721,     32'd20860,
		32'd10430,     32'd5215,      32'd2607,      32'd1303,
		32'd651,       32'd325,       32'd162,       32'd81
	};

	typedef struct packed {
		logic                 func;
		logic                 zero;
		logic signed [XW-1:0] x;
		logic signed [XW-1:0] y;
		logic signed [ZW-1:0] z;
	} cord_t;

	function automatic logic [ZW-1:0] atan_at(input logic [SHW-1:0] idx);
		logic [ZW-1:0] r;
		r = '0;
		if (int'(idx) < NTAB) begin
			r = ZW'(ATAN_TAB[idx]);
		end
		return r;
	endfunction

	function automatic logic signed [OW-1:0] sat_o(input logic signed [SATW-1:0] v);
		logic signed [SATW-1:0] hi_lim;
		logic signed [SATW-1:0] lo_lim;
		logic signed [SATW-1:0] r;
		hi_lim = SATW'((64'sd1 <<< DATA_W) - 64'sd1);
		lo_lim = -hi_lim - SATW'(1);
		r = v;
		if (v > hi_lim) begin
			r = hi_lim;
		end else if (v < lo_lim) begin
			r = lo_lim;
		end
		return r[OW-1:0];
	endfunction

endpackage

// ===== design/vpr_pre.sv =====
// Input stage: quadrant pre-rotation and start angle.
`timescale 1ns / 1ps
module vpr_pre import vpr_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic                    vld_in,
	input  logic                    func,
	input  logic signed [DATA_W-1:0] x_in,
	input  logic signed [DATA_W-1:0] y_in,
	input  logic signed [ANG_W-1:0]  angle_in,
	output logic                    vld_q,
	output cord_t                   data_q
);

	logic signed [XW-1:0] xe;
	logic signed [XW-1:0] ye;
	logic signed [ZW-1:0] za;
	cord_t nxt;

	always_comb begin
		xe = XW'(x_in) <<< GUARD_W;
		ye = XW'(y_in) <<< GUARD_W;
		za = ZW'(angle_in) <<< ANG_SH;
		nxt.func = func;
		nxt.zero = 1'b0;
		nxt.x = xe;
		nxt.y = ye;
		nxt.z = '0;
		if (!func) begin
			nxt.zero = (x_in == '0) && (y_in == '0);
			if (x_in[DATA_W-1]) begin
				if (!y_in[DATA_W-1]) begin
					nxt.x = ye;
					nxt.y = -xe;
					nxt.z = QUARTER;
				end else begin
					nxt.x = -ye;
					nxt.y = xe;
					nxt.z = -QUARTER;
				end
			end
		end else begin
			nxt.z = za;
			if (za > QUARTER) begin
				nxt.x = -ye;
				nxt.y = xe;
				nxt.z = za - QUARTER;
			end else if (za < -QUARTER) begin
				nxt.x = ye;
				nxt.y = -xe;
				nxt.z = za + QUARTER;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_q <= nxt;
		end
	end

endmodule

// ===== design/vpr_cell.sv =====
// One CORDIC micro-rotation cell of the pipeline chain.
`timescale 1ns / 1ps
module vpr_cell import vpr_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           vld_in,
	input  logic [SHW-1:0] shift,
	input  logic [ZW-1:0]  atan,
	input  cord_t          d,
	output logic           vld_q,
	output cord_t          data_q
);

	logic signed [XW-1:0] xv;
	logic signed [XW-1:0] yv;
	logic signed [ZW-1:0] zv;
	logic signed [XW-1:0] xs;
	logic signed [XW-1:0] ys;
	logic signed [ZW-1:0] at;
	logic                 sel;
	cord_t nxt;

	always_comb begin
		xv = d.x;
		yv = d.y;
		zv = d.z;
		at = $signed(atan);
		xs = xv >>> shift;
		ys = yv >>> shift;
		sel = d.func ? zv[ZW-1] : ~yv[XW-1];
		nxt = d;
		if (sel) begin
			nxt.x = xv + ys;
			nxt.y = yv - xs;
			nxt.z = zv + at;
		end else begin
			nxt.x = xv - ys;
			nxt.y = yv + xs;
			nxt.z = zv - at;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_q <= nxt;
		end
	end

endmodule

// ===== design/vpr_post.sv =====
// Output stages: gain removal by split multiply, rounding and saturation.
`timescale 1ns / 1ps
module vpr_post import vpr_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en1,
	input  logic                 en2,
	input  logic                 vld_in,
	input  cord_t                d,
	output logic                 vld_s1,
	output logic                 vld_q,
	output logic                 func_q,
	output logic signed [OW-1:0] a_q,
	output logic signed [OW-1:0] b_q
);

	logic signed [HIW-1:0]       hi_x;
	logic signed [HIW-1:0]       hi_y;
	logic [SPLIT-1:0]            lo_x;
	logic [SPLIT-1:0]            lo_y;
	logic signed [GW:0]          gs;
	logic signed [HPW-1:0]       hpx;
	logic signed [HPW-1:0]       hpy;
	logic [SPLIT+GW-1:0]         lpx;
	logic [SPLIT+GW-1:0]         lpy;
	logic signed [ZW:0]          zr;
	logic signed [AW-1:0]        ang;

	logic                        func_s1;
	logic                        zero_s1;
	logic signed [HPW-1:0]       hx_s1;
	logic signed [HPW-1:0]       hy_s1;
	logic [GW-1:0]               lx_s1;
	logic [GW-1:0]               ly_s1;
	logic signed [OW-1:0]        ang_s1;

	logic signed [QW-1:0]        qx;
	logic signed [QW-1:0]        qy;
	logic signed [RW-1:0]        gx;
	logic signed [RW-1:0]        gy;
	logic signed [RW-1:0]        mag;
	logic signed [OW-1:0]        a_nxt;
	logic signed [OW-1:0]        b_nxt;

	always_comb begin
		hi_x = d.x[XW-1:SPLIT];
		hi_y = d.y[XW-1:SPLIT];
		lo_x = d.x[SPLIT-1:0];
		lo_y = d.y[SPLIT-1:0];
		gs   = $signed({1'b0, GAIN});
		hpx  = hi_x * gs;
		hpy  = hi_y * gs;
		lpx  = lo_x * GAIN;
		lpy  = lo_y * GAIN;
		zr   = (ZW + 1)'(d.z) + ANG_RND;
		ang  = zr[ZW:ANG_SH];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en1) begin
			vld_s1 <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			func_s1 <= d.func;
			zero_s1 <= d.zero;
			hx_s1   <= hpx;
			hy_s1   <= hpy;
			lx_s1   <= lpx[SPLIT+GW-1:SPLIT];
			ly_s1   <= lpy[SPLIT+GW-1:SPLIT];
			ang_s1  <= sat_o(SATW'(ang));
		end
	end

	always_comb begin
		qx  = QW'(hx_s1) + QW'($signed({1'b0, lx_s1})) + RND;
		qy  = QW'(hy_s1) + QW'($signed({1'b0, ly_s1})) + RND;
		gx  = qx[QW-1:SPLIT];
		gy  = qy[QW-1:SPLIT];
		mag = gx[RW-1] ? '0 : gx;
		if (zero_s1) begin
			a_nxt = '0;
			b_nxt = '0;
		end else if (func_s1) begin
			a_nxt = sat_o(SATW'(gx));
			b_nxt = sat_o(SATW'(gy));
		end else begin
			a_nxt = ang_s1;
			b_nxt = sat_o(SATW'(mag));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en2) begin
			vld_q <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			func_q <= func_s1;
			a_q    <= a_nxt;
			b_q    <= b_nxt;
		end
	end

endmodule

// ===== design/vector_polar_rotate_top.sv =====
// Throughput: one beat per cycle while result_ready holds; one pre-rotation stage, one cell
// per CORDIC iteration and two gain/rounding stages, each advancing when it is empty or its
// successor advances, so bubbles fill while a result waits.
// Reset: arst_n clears all stage valid flags; datapath registers are not reset.
`timescale 1ns / 1ps
module vector_polar_rotate_top import vpr_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     item_valid,
	output logic                     item_ready,
	input  logic                     func,
	input  logic signed [DATA_W-1:0] x_in,
	input  logic signed [DATA_W-1:0] y_in,
	input  logic signed [ANG_W-1:0]  angle_in,
	output logic                     result_valid,
	input  logic                     result_ready,
	output logic signed [OW-1:0]     out_a,
	output logic signed [OW-1:0]     out_b
);

	localparam int NST = ITER + 3;

	logic [NST-1:0] vld;
	logic [NST-1:0] en;
	cord_t          stg [ITER+1];
	logic           res_func;

	assign en[NST-1] = ~vld[NST-1] | result_ready;

	genvar k;
	generate
		for (k = 0; k < NST - 1; k++) begin : g_en
			assign en[k] = ~vld[k] | en[k+1];
		end
	endgenerate

	assign item_ready   = en[0];
	assign result_valid = vld[NST-1];

	vpr_pre u_pre (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en[0]),
		.vld_in   (item_valid),
		.func     (func),
		.x_in     (x_in),
		.y_in     (y_in),
		.angle_in (angle_in),
		.vld_q    (vld[0]),
		.data_q   (stg[0])
	);

	generate
		for (k = 0; k < ITER; k++) begin : g_cell
			vpr_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.en     (en[k+1]),
				.vld_in (vld[k]),
				.shift  (SHW'(k)),
				.atan   (atan_at(SHW'(k))),
				.d      (stg[k]),
				.vld_q  (vld[k+1]),
				.data_q (stg[k+1])
			);
		end
	endgenerate

	vpr_post u_post (
		.clk    (clk),
		.arst_n (arst_n),
		.en1    (en[ITER+1]),
		.en2    (en[ITER+2]),
		.vld_in (vld[ITER]),
		.d      (stg[ITER]),
		.vld_s1 (vld[ITER+1]),
		.vld_q  (vld[ITER+2]),
		.func_q (res_func),
		.a_q    (out_a),
		.b_q    (out_b)
	);

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid |-> item_ready)
		else $error("input stalled with empty output register");

	a_ready_follows_sink: assert property (@(posedge clk) disable iff (!arst_n)
		result_ready |-> item_ready)
		else $error("input stalled while sink takes results");

	a_accept_loads_pre: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> vld[0])
		else $error("accepted beat lost at input stage");

	a_mag_nonneg: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !res_func |-> !out_b[OW-1])
		else $error("negative magnitude in polar result");

endmodule
